@@ rtl/bbm_pkg.sv @@
package bbm_pkg;

  localparam int unsigned STORE_BYTES_DEF = 131072;
  localparam int unsigned BANK_BYTES_DEF  = 16384;

  localparam int unsigned SUM_W = 18;

  localparam logic [2:0] CMD_SLEEP   = 3'd0;
  localparam logic [2:0] CMD_ACK     = 3'd1;
  localparam logic [2:0] CMD_LINE0   = 3'd2;
  localparam logic [2:0] CMD_LINE2   = 3'd3;
  localparam logic [2:0] CMD_LINE3   = 3'd4;
  localparam logic [2:0] CMD_WRITE   = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;
  localparam logic [2:0] CMD_PRELOAD = 3'd7;

  localparam logic [2:0] MODEL_4K    = 3'd0;
  localparam logic [2:0] MODEL_8K    = 3'd1;
  localparam logic [2:0] MODEL_16K   = 3'd2;
  localparam logic [2:0] MODEL_16K_R = 3'd3;
  localparam logic [2:0] MODEL_2BANK = 3'd4;
  localparam logic [2:0] MODEL_8BANK = 3'd5;
  localparam logic [2:0] MODEL_ROM   = 3'd6;

  localparam logic [1:0] REG_MODEL   = 2'd0;
  localparam logic [1:0] REG_ROM_SW  = 2'd1;
  localparam logic [1:0] REG_ROM_OFS = 2'd2;

  localparam logic [4:0] DEST_MAIN = 5'd0;
  localparam logic [4:0] DEST_ALT  = 5'd30;

  localparam logic [16:0] ADDR_ROM_LO = 17'h04000;
  localparam logic [16:0] ADDR_WIN_LO = 17'h08000;
  localparam logic [16:0] ADDR_END_4K = 17'h09000;
  localparam logic [16:0] ADDR_END_8K = 17'h0A000;
  localparam logic [16:0] ADDR_END_16 = 17'h0C000;

  localparam logic [7:0] ID_RAM     = 8'hFB;
  localparam logic [7:0] ID_ROM     = 8'hF7;
  localparam logic [7:0] LINE3_BYTE = 8'hFF;
  localparam logic [7:0] SEL_ROM_SW = 8'd128;
  localparam logic [7:0] FILL_BYTE  = 8'h7F;

  typedef struct packed {
    logic       drive;
    logic [2:0] func;
    logic [7:0] dout;
    logic       mem_we;
    logic       mem_re;
    logic       sel_we;
    logic       powered;
    logic [2:0] bank;
  } act_t;

endpackage

@@ rtl/bbm_ram.sv @@
module bbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bbm_decode.sv @@
module bbm_decode #(
  parameter int unsigned STORE_BYTES = bbm_pkg::STORE_BYTES_DEF,
  parameter int unsigned BANK_BYTES  = bbm_pkg::BANK_BYTES_DEF,
  localparam int unsigned AW         = $clog2(STORE_BYTES)
) (
  input  logic [2:0]       cmd_i,
  input  logic [4:0]       dest_i,
  input  logic             is_write_i,
  input  logic [16:0]      addr_i,
  input  logic [7:0]       data_in_i,
  input  logic [2:0]       model_i,
  input  logic             rom_sw_i,
  input  logic [8:0]       rom_ofs_i,
  input  logic             powered_i,
  input  logic [2:0]       bank_i,
  output bbm_pkg::act_t    act_o,
  output logic [AW-1:0]    mem_addr_o
);

  localparam int unsigned SW = bbm_pkg::SUM_W;
  localparam logic [SW-1:0] BANK_W = SW'(BANK_BYTES);

  logic [16:0]   win_end;
  logic          in_win;
  logic          in_rom;
  logic          banked;
  logic [SW-1:0] bank_base;
  logic [SW-1:0] win_idx;
  logic [SW-1:0] ofs_idx;
  logic [SW-1:0] car_idx;
  logic          sel_pwr;
  logic [2:0]    sel_bank;

  always_comb begin
    unique case (model_i)
      bbm_pkg::MODEL_4K:    win_end = bbm_pkg::ADDR_END_4K;
      bbm_pkg::MODEL_8K:    win_end = bbm_pkg::ADDR_END_8K;
      bbm_pkg::MODEL_16K,
      bbm_pkg::MODEL_16K_R,
      bbm_pkg::MODEL_2BANK,
      bbm_pkg::MODEL_8BANK: win_end = bbm_pkg::ADDR_END_16;
      default:              win_end = '0;
    endcase
  end

  assign in_win    = (addr_i >= bbm_pkg::ADDR_WIN_LO) && (addr_i < win_end);
  assign in_rom    = (addr_i >= bbm_pkg::ADDR_ROM_LO) && (addr_i < bbm_pkg::ADDR_WIN_LO);
  assign banked    = (model_i == bbm_pkg::MODEL_2BANK) || (model_i == bbm_pkg::MODEL_8BANK);
  assign bank_base = SW'(bank_i) * BANK_W;
  assign win_idx   = {1'b0, addr_i} - {1'b0, bbm_pkg::ADDR_WIN_LO}
                   + (banked ? bank_base : '0);
  assign ofs_idx   = {1'b0, addr_i} - {1'b0, bbm_pkg::ADDR_ROM_LO} + SW'(rom_ofs_i);
  assign car_idx   = {1'b0, addr_i} - {1'b0, bbm_pkg::ADDR_ROM_LO} + bank_base;

  always_comb begin
    sel_pwr  = 1'b0;
    sel_bank = '0;
    if (rom_sw_i) begin
      sel_pwr = (data_in_i == bbm_pkg::SEL_ROM_SW);
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (data_in_i == 8'(1 << i)) begin
          if (model_i == bbm_pkg::MODEL_ROM) begin
            sel_pwr  = 1'b1;
            sel_bank = 3'(7 - i);
          end else if (i == 0 || (i == 1 && model_i == bbm_pkg::MODEL_2BANK)
                       || model_i == bbm_pkg::MODEL_8BANK) begin
            sel_pwr  = 1'b1;
            sel_bank = 3'(i);
          end
        end
      end
    end
  end

  always_comb begin
    act_o        = '0;
    act_o.func   = cmd_i;
    act_o.dout   = data_in_i;
    mem_addr_o   = addr_i[AW-1:0];
    if (cmd_i == bbm_pkg::CMD_PRELOAD) begin
      act_o.mem_we = 1'b1;
    end else if (cmd_i == bbm_pkg::CMD_SLEEP
                 || (dest_i != bbm_pkg::DEST_MAIN && dest_i != bbm_pkg::DEST_ALT)) begin
      act_o.drive = 1'b0;
    end else if (cmd_i == bbm_pkg::CMD_LINE0 && !is_write_i) begin
      act_o.drive = 1'b1;
      act_o.func  = bbm_pkg::CMD_READ;
      act_o.dout  = (rom_sw_i || model_i == bbm_pkg::MODEL_ROM) ? bbm_pkg::ID_ROM
                                                                : bbm_pkg::ID_RAM;
    end else if (cmd_i == bbm_pkg::CMD_LINE2 && is_write_i) begin
      act_o.sel_we  = 1'b1;
      act_o.powered = sel_pwr;
      act_o.bank    = sel_bank;
      if (sel_pwr) begin
        act_o.drive = 1'b1;
        act_o.func  = bbm_pkg::CMD_READ;
        act_o.dout  = '0;
      end
    end else if (powered_i) begin
      act_o.drive = 1'b1;
      unique case (cmd_i)
        bbm_pkg::CMD_WRITE: begin
          act_o.mem_we = in_win;
          mem_addr_o   = win_idx[AW-1:0];
        end
        bbm_pkg::CMD_READ: begin
          if (model_i == bbm_pkg::MODEL_16K_R && rom_sw_i && in_rom) begin
            act_o.func   = bbm_pkg::CMD_ACK;
            act_o.mem_re = 1'b1;
            mem_addr_o   = ofs_idx[AW-1:0];
          end else if (model_i == bbm_pkg::MODEL_ROM) begin
            if (in_rom) begin
              act_o.func   = bbm_pkg::CMD_ACK;
              act_o.mem_re = 1'b1;
              mem_addr_o   = car_idx[AW-1:0];
            end
          end else if (in_win) begin
            act_o.mem_re = 1'b1;
            mem_addr_o   = win_idx[AW-1:0];
          end
        end
        bbm_pkg::CMD_LINE3: begin
          act_o.func = bbm_pkg::CMD_READ;
          act_o.dout = bbm_pkg::LINE3_BYTE;
        end
        default: act_o.drive = 1'b1;
      endcase
    end
  end

endmodule

@@ rtl/banked_bus_memory_module.sv @@
// Banked RAM/ROM expansion module answering one peripheral bus cycle per input
// transfer (cmd in tuser; dest, direction, address and data in tdata). Every
// transfer yields exactly one result transfer. Most results are loaded straight
// into the output register; a read that hits the store first passes through the
// registered read port of the single-port store RAM (the ST_READ state). After
// reset the store is swept to 0x7F, one byte per clock, over all STORE_BYTES
// bytes (131072 by default); no bus transfer is taken during the sweep,
// configuration writes are. STORE_BYTES must be a power of two; store indices
// wrap modulo its size. Write configuration only while no transfer is outstanding.
module banked_bus_memory_module #(
  parameter int unsigned STORE_BYTES = bbm_pkg::STORE_BYTES_DEF,
  parameter int unsigned BANK_BYTES  = bbm_pkg::BANK_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dest[4:0], is_write[5], addr[22:6], data_in[30:23], zero[31]
  input  logic [31:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive[0], data_out[8:1], zero[15:9]
  output logic [15:0] m_axis_tdata,
  // func_out[2:0]
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

  state_e        state_q;
  logic [AW-1:0] clr_q;
  logic [2:0]    model_q;
  logic          rom_sw_q;
  logic [8:0]    rom_ofs_q;
  logic          powered_q;
  logic [2:0]    bank_q;
  logic          out_valid_q;
  logic          out_drive_q;
  logic [2:0]    out_func_q;
  logic [7:0]    out_data_q;
  logic [2:0]    pend_func_q;

  bbm_pkg::act_t act;
  logic [AW-1:0] dec_addr;
  logic          s_fire;
  logic          out_free;
  logic          out_load;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  bbm_decode #(
    .STORE_BYTES(STORE_BYTES),
    .BANK_BYTES (BANK_BYTES)
  ) u_decode (
    .cmd_i      (s_axis_tuser),
    .dest_i     (s_axis_tdata[4:0]),
    .is_write_i (s_axis_tdata[5]),
    .addr_i     (s_axis_tdata[22:6]),
    .data_in_i  (s_axis_tdata[30:23]),
    .model_i    (model_q),
    .rom_sw_i   (rom_sw_q),
    .rom_ofs_i  (rom_ofs_q),
    .powered_i  (powered_q),
    .bank_i     (bank_q),
    .act_o      (act),
    .mem_addr_o (dec_addr)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_READ) || (s_fire && !act.mem_re);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = clr_q;
      ram_wdata = bbm_pkg::FILL_BYTE;
    end else begin
      ram_we    = s_fire && act.mem_we;
      ram_re    = s_fire && act.mem_re;
      ram_addr  = dec_addr;
      ram_wdata = s_axis_tdata[30:23];
    end
  end

  bbm_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      model_q     <= bbm_pkg::MODEL_4K;
      rom_sw_q    <= 1'b0;
      rom_ofs_q   <= 9'd14;
      powered_q   <= 1'b0;
      bank_q      <= '0;
      out_valid_q <= 1'b0;
      out_drive_q <= 1'b0;
      out_func_q  <= '0;
      out_data_q  <= '0;
      pend_func_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bbm_pkg::REG_MODEL:   model_q   <= cfg_data_i[2:0];
          bbm_pkg::REG_ROM_SW:  rom_sw_q  <= cfg_data_i[0];
          bbm_pkg::REG_ROM_OFS: rom_ofs_q <= cfg_data_i;
          default:              model_q   <= model_q;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(STORE_BYTES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            if (act.sel_we) begin
              powered_q <= act.powered;
              bank_q    <= act.bank;
            end
            if (act.mem_re) begin
              pend_func_q <= act.func;
              state_q     <= ST_READ;
            end else begin
              out_drive_q <= act.drive;
              out_func_q  <= act.func;
              out_data_q  <= act.dout;
            end
          end
        end
        ST_READ: begin
          out_drive_q <= 1'b1;
          out_func_q  <= pend_func_q;
          out_data_q  <= ram_rdata;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_data_q, out_drive_q};
  assign m_axis_tuser  = out_func_q;

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("transfer taken during store sweep");

  a_no_take_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !s_axis_tready)
    else $error("transfer taken while store read pending");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && act.mem_re) |=> ##1 (m_axis_tvalid && m_axis_tdata[0]))
    else $error("store read result missing");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

endmodule

@@ verif/tb_banked_bus_memory_module.sv @@
`timescale 1ns / 1ps

module tb_banked_bus_memory_module;
  import bbm_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  dest;
    logic        is_write;
    logic [16:0] addr;
    logic [7:0]  data;
  } bus_cycle_t;

  typedef struct packed {
    logic       drive;
    logic [2:0] func;
    logic [7:0] dout;
  } bus_reply_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [8:0]  reg_val;
    bus_cycle_t  cyc;
    bit          fixed;
    bus_reply_t  want;
  } probe_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  logic [2:0]  cfg_model = MODEL_4K;
  logic        cfg_rom_sw = 1'b0;
  logic [8:0]  cfg_rom_ofs = 9'd14;
  logic        mod_powered = 1'b0;
  logic [2:0]  mod_bank = 3'd0;
  logic [7:0]  store_mirror [0:STORE_BYTES_DEF-1];

  bus_reply_t  pending_replies [$];
  probe_row_t  probe_rows [$];
  int          mismatch_count = 0;
  int          replies_seen = 0;
  bit          steady_phase = 1'b0;

  int phase_model [11] = '{0, 1, 2, 3, 3, 4, 5, 6, 6, 3, 5};
  int phase_rom_sw [11] = '{0, 0, 0, 1, 1, 0, 0, 0, 1, 0, 1};
  int phase_rom_ofs [11] = '{14, 269, 14, 14, 269, 100, 14, 269, 14, 14, 200};

  banked_bus_memory_module uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic bus_reply_t serve_bus_cycle(bus_cycle_t c);
    bus_reply_t  r;
    logic [16:0] wend;
    logic [16:0] wbase;
    logic [16:0] idx;
    logic        in_win;
    logic        in_rom;
    int          i;
    r.drive = 1'b0;
    r.func = c.cmd;
    r.dout = c.data;
    if (c.cmd == CMD_PRELOAD) begin
      store_mirror[c.addr] = c.data;
    end else if (c.cmd == CMD_SLEEP || (c.dest != DEST_MAIN && c.dest != DEST_ALT)) begin
      r.drive = 1'b0;
    end else if (c.cmd == CMD_LINE0 && !c.is_write) begin
      r.drive = 1'b1;
      r.func = CMD_READ;
      r.dout = (cfg_rom_sw || cfg_model == MODEL_ROM) ? ID_ROM : ID_RAM;
    end else if (c.cmd == CMD_LINE2 && c.is_write) begin
      mod_powered = 1'b0;
      mod_bank = 3'd0;
      if (cfg_rom_sw) begin
        mod_powered = (c.data == SEL_ROM_SW);
      end else begin
        for (i = 0; i < 8; i++) begin
          if (c.data == (8'd1 << i)) begin
            if (cfg_model == MODEL_ROM) begin
              mod_powered = 1'b1;
              mod_bank = 3'(7 - i);
            end else if (i == 0 || (i == 1 && cfg_model == MODEL_2BANK) ||
                         cfg_model == MODEL_8BANK) begin
              mod_powered = 1'b1;
              mod_bank = 3'(i);
            end
          end
        end
      end
      if (mod_powered) begin
        r.drive = 1'b1;
        r.func = CMD_READ;
        r.dout = 8'd0;
      end
    end else if (mod_powered) begin
      case (cfg_model)
        MODEL_4K: wend = ADDR_END_4K;
        MODEL_8K: wend = ADDR_END_8K;
        MODEL_16K, MODEL_16K_R, MODEL_2BANK, MODEL_8BANK: wend = ADDR_END_16;
        default: wend = 17'd0;
      endcase
      wbase = (cfg_model == MODEL_2BANK || cfg_model == MODEL_8BANK) ?
              {mod_bank, 14'd0} : 17'd0;
      in_win = (c.addr >= ADDR_WIN_LO) && (c.addr < wend);
      in_rom = (c.addr >= ADDR_ROM_LO) && (c.addr < ADDR_WIN_LO);
      r.drive = 1'b1;
      if (c.cmd == CMD_WRITE) begin
        idx = c.addr - ADDR_WIN_LO + wbase;
        if (in_win) store_mirror[idx] = c.data;
      end else if (c.cmd == CMD_READ) begin
        if (cfg_model == MODEL_16K_R && cfg_rom_sw && in_rom) begin
          idx = c.addr - ADDR_ROM_LO + {8'd0, cfg_rom_ofs};
          r.func = CMD_ACK;
          r.dout = store_mirror[idx];
        end else if (cfg_model == MODEL_ROM) begin
          if (in_rom) begin
            idx = c.addr - ADDR_ROM_LO + {mod_bank, 14'd0};
            r.func = CMD_ACK;
            r.dout = store_mirror[idx];
          end
        end else if (in_win) begin
          idx = c.addr - ADDR_WIN_LO + wbase;
          r.dout = store_mirror[idx];
        end
      end else if (c.cmd == CMD_LINE3) begin
        r.func = CMD_READ;
        r.dout = LINE3_BYTE;
      end
    end
    return r;
  endfunction

  function automatic bus_cycle_t draw_bus_cycle();
    bus_cycle_t  c;
    int          pick;
    logic [16:0] off;
    logic [16:0] bank_base;
    c.dest = $urandom_range(0, 1) ? DEST_MAIN : DEST_ALT;
    c.is_write = 1'($urandom_range(0, 1));
    c.data = 8'($urandom_range(0, 255));
    off = 17'($urandom_range(0, 63));
    bank_base = {3'($urandom_range(0, 7)), 14'd0};
    case ($urandom_range(0, 5))
      0: c.addr = ADDR_ROM_LO + off;
      1: c.addr = ADDR_WIN_LO + off;
      2: c.addr = ADDR_WIN_LO - 17'd32 + off;
      3: c.addr = ADDR_END_4K - 17'd32 + off;
      4: c.addr = ($urandom_range(0, 1) ? ADDR_END_8K : ADDR_END_16) - 17'd32 + off;
      default: c.addr = 17'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      c.cmd = CMD_LINE2;
      c.is_write = 1'b1;
      if (pick < 6) begin
        if (cfg_rom_sw)
          c.data = ($urandom_range(0, 3) != 0) ? SEL_ROM_SW : 8'd1 << $urandom_range(0, 7);
        else if ($urandom_range(0, 1) && cfg_model != MODEL_ROM)
          c.data = 8'd1;
        else
          c.data = 8'd1 << $urandom_range(0, 7);
      end
    end else if (pick < 14) begin
      c.cmd = CMD_PRELOAD;
      c.dest = 5'($urandom_range(0, 31));
      case ($urandom_range(0, 4))
        0: c.addr = bank_base + off;
        1: c.addr = {8'd0, cfg_rom_ofs} + off;
        2: c.addr = bank_base + 17'h00FE0 + off;
        3: c.addr = bank_base + 17'h03FE0 + off;
        default: c.addr = 17'($urandom);
      endcase
    end else if (pick < 18) begin
      c.cmd = CMD_LINE0;
    end else if (pick < 23) begin
      c.cmd = 3'($urandom_range(0, 7));
      c.dest = 5'($urandom_range(0, 31));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c.cmd = CMD_WRITE;
        4, 5, 6, 7: c.cmd = CMD_READ;
        8: c.cmd = CMD_LINE3;
        default: c.cmd = CMD_ACK;
      endcase
    end
    return c;
  endfunction

  function automatic void add_probe(logic [2:0] cmd, logic [4:0] dest, logic wr,
                                    logic [16:0] addr, logic [7:0] data, bit fixed,
                                    logic drive, logic [2:0] func, logic [7:0] dout);
    probe_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.cyc = '{cmd: cmd, dest: dest, is_write: wr, addr: addr, data: data};
    row.fixed = fixed;
    row.want = '{drive: drive, func: func, dout: dout};
    probe_rows.push_back(row);
  endfunction

  function automatic void add_setting(logic [1:0] idx, logic [8:0] val);
    probe_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.cyc = '0;
    row.fixed = 1'b0;
    row.want = '0;
    probe_rows.push_back(row);
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [8:0] val);
    s_axis_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_MODEL: cfg_model = val[2:0];
      REG_ROM_SW: cfg_rom_sw = val[0];
      REG_ROM_OFS: cfg_rom_ofs = val;
      default: ;
    endcase
  endtask

  task automatic offer_bus_cycle(input bus_cycle_t c, input bit fixed, input bus_reply_t want);
    int         gap;
    bus_reply_t predicted;
    gap = steady_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = c.cmd;
    s_axis_tdata = {1'b0, c.data, c.addr, c.is_write, c.dest};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    predicted = serve_bus_cycle(c);
    pending_replies.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  initial begin
    int         gap;
    bus_reply_t got;
    bus_reply_t want;
    @(posedge rst_ni);
    forever begin
      gap = steady_phase ? 0 : $urandom_range(0, 5);
      // hold off long enough to back up the block and stall its input
      if (replies_seen == 400) gap = 600;
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do begin
        @(posedge clk_i);
      end while (!m_axis_tvalid);
      got.drive = m_axis_tdata[0];
      got.dout = m_axis_tdata[8:1];
      got.func = m_axis_tuser;
      @(negedge clk_i);
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected transfer drive=%0d func=%0d data=%02h",
                   $realtime, got.drive, got.func, got.dout);
      end else begin
        want = pending_replies.pop_front();
        if (got.drive !== want.drive || got.func !== want.func || got.dout !== want.dout) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch want drive=%0d func=%0d data=%02h, got drive=%0d func=%0d data=%02h",
                     $realtime, want.drive, want.func, want.dout,
                     got.drive, got.func, got.dout);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_banked_bus_memory_module: errors");
    $finish;
  end

  initial begin
    int         ph;
    int         counted;
    logic [8:0] m_val;
    logic [8:0] s_val;
    logic [8:0] o_val;
    bus_cycle_t c;
    for (int k = 0; k < STORE_BYTES_DEF; k++) store_mirror[k] = FILL_BYTE;

    add_probe(CMD_LINE0, DEST_MAIN, 1'b0, 17'h00000, 8'h00, 1, 1'b1, CMD_READ, ID_RAM);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, ADDR_WIN_LO, 8'h55, 1, 1'b0, CMD_READ, 8'h55);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h01, 1, 1'b1, CMD_READ, 8'h00);
    add_probe(CMD_READ, DEST_ALT, 1'b0, ADDR_WIN_LO, 8'h12, 1, 1'b1, CMD_READ, FILL_BYTE);
    add_probe(CMD_WRITE, DEST_ALT, 1'b1, 17'h08FFF, 8'hA5, 1, 1'b1, CMD_WRITE, 8'hA5);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, 17'h08FFF, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, ADDR_END_4K, 8'h3C, 1, 1'b1, CMD_READ, 8'h3C);
    add_probe(CMD_LINE3, DEST_MAIN, 1'b0, 17'h1FFFF, 8'h00, 1, 1'b1, CMD_READ, LINE3_BYTE);
    add_probe(CMD_ACK, DEST_MAIN, 1'b1, 17'h00000, 8'h81, 1, 1'b1, CMD_ACK, 8'h81);
    add_probe(CMD_SLEEP, DEST_MAIN, 1'b0, 17'h00000, 8'hFF, 1, 1'b0, CMD_SLEEP, 8'hFF);
    add_probe(CMD_READ, 5'd31, 1'b0, ADDR_WIN_LO, 8'h00, 1, 1'b0, CMD_READ, 8'h00);
    add_probe(CMD_PRELOAD, 5'd17, 1'b1, 17'h1FFFF, 8'hFF, 1, 1'b0, CMD_PRELOAD, 8'hFF);
    add_probe(CMD_PRELOAD, DEST_MAIN, 1'b0, 17'h00000, 8'h00, 1, 1'b0, CMD_PRELOAD, 8'h00);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, ADDR_WIN_LO, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_LINE0, DEST_MAIN, 1'b1, 17'h00000, 8'h11, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h02, 1, 1'b0, CMD_LINE2, 8'h02);
    add_probe(CMD_LINE3, DEST_ALT, 1'b0, 17'h00000, 8'h5A, 1, 1'b0, CMD_LINE3, 8'h5A);
    add_setting(REG_MODEL, {6'd0, MODEL_ROM});
    add_setting(REG_ROM_OFS, 9'd269);
    add_probe(CMD_LINE0, DEST_MAIN, 1'b0, 17'h00000, 8'h00, 1, 1'b1, CMD_READ, ID_ROM);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h80, 1, 1'b1, CMD_READ, 8'h00);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, 17'h07FFF, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h01, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_READ, DEST_ALT, 1'b0, 17'h07FFF, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_setting(REG_MODEL, {6'd0, MODEL_16K_R});
    add_setting(REG_ROM_SW, 9'd1);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h01, 1, 1'b0, CMD_LINE2, 8'h01);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, SEL_ROM_SW, 1, 1'b1, CMD_READ, 8'h00);
    add_probe(CMD_PRELOAD, DEST_MAIN, 1'b1, 17'd269, 8'hC3, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, ADDR_ROM_LO, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_setting(REG_MODEL, {6'd0, MODEL_8BANK});
    add_setting(REG_ROM_SW, 9'd0);
    add_probe(CMD_LINE2, DEST_MAIN, 1'b1, 17'h00000, 8'h80, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_WRITE, DEST_MAIN, 1'b1, 17'h0BFFF, 8'h99, 0, 1'b0, CMD_SLEEP, 8'h00);
    add_probe(CMD_READ, DEST_MAIN, 1'b0, 17'h0BFFF, 8'h00, 0, 1'b0, CMD_SLEEP, 8'h00);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_rows[i]) begin
      if (probe_rows[i].is_cfg)
        write_register(probe_rows[i].reg_idx, probe_rows[i].reg_val);
      else
        offer_bus_cycle(probe_rows[i].cyc, probe_rows[i].fixed, probe_rows[i].want);
    end

    for (ph = 0; ph < 15; ph++) begin
      if (ph < 11) begin
        m_val = 9'(phase_model[ph]);
        s_val = 9'(phase_rom_sw[ph]);
        o_val = 9'(phase_rom_ofs[ph]);
      end else begin
        m_val = 9'($urandom_range(0, 6));
        s_val = 9'($urandom_range(0, 1));
        o_val = 9'($urandom_range(14, 269));
      end
      write_register(REG_MODEL, m_val);
      write_register(REG_ROM_SW, s_val);
      write_register(REG_ROM_OFS, o_val);
      steady_phase = (ph % 4 == 2);
      counted = 0;
      while (counted < 100) begin
        c = draw_bus_cycle();
        offer_bus_cycle(c, 1'b0, '0);
        if (c.cmd == CMD_PRELOAD ||
            (c.cmd != CMD_SLEEP && (c.dest == DEST_MAIN || c.dest == DEST_ALT)))
          counted++;
      end
    end

    steady_phase = 1'b0;
    s_axis_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("tb_banked_bus_memory_module: clean");
    else
      $display("tb_banked_bus_memory_module: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bbm_pkg.sv
rtl/bbm_ram.sv
rtl/bbm_decode.sv
rtl/banked_bus_memory_module.sv
verif/tb_banked_bus_memory_module.sv
